// ===== design/tcp_segment_tracker_assert.svh =====
// ---------------------------------------------------------------------------
// tcp_segment_tracker_assert.svh
// Assertion macros for the segment tracker; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef TCP_SEGMENT_TRACKER_ASSERT_SVH
`define TCP_SEGMENT_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define TST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcp_segment_tracker assertion failed");
// next-cycle implication
`define TST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcp_segment_tracker assertion failed");
`else
`define TST_ASSERT_NOW(label, ante, cons)
`define TST_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/tst_pkg.sv =====
// ---------------------------------------------------------------------------
// tst_pkg
// Types and codes shared by the segment tracker modules.
// ---------------------------------------------------------------------------
`default_nettype none
package tst_pkg;

	localparam int SEQ_W  = 32;
	localparam int SIZE_W = 16;
	localparam int CNT_W  = 32;
	localparam int CFG_W  = 32;
	localparam int CFG_IDX_W = 3;

	// opcodes
	localparam logic OP_OPEN = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	// result status codes
	localparam logic [2:0] STAT_INSERTED = 3'd0;
	localparam logic [2:0] STAT_REPLACED = 3'd1;
	localparam logic [2:0] STAT_COMPLETE = 3'd2;
	localparam logic [2:0] STAT_FOREIGN  = 3'd3;
	localparam logic [2:0] STAT_FULL     = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_ADDR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_PORT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_PORT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACK        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE = 3'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LAUNCH,
		S_SCAN
	} state_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              pv;
		logic              hit;
		logic [SIZE_W-1:0] hit_size;
		logic              free;
	} probe_t;

	// table update broadcast to every cell
	typedef struct packed {
		logic              open;
		logic              replace;
		logic              insert;
		logic [SEQ_W-1:0]  seq;
		logic [SIZE_W-1:0] size;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/tst_chan_ifs.sv =====
// ---------------------------------------------------------------------------
// tst_chan_ifs
// Valid/ready channels for segment headers in and tracker results out.
// ---------------------------------------------------------------------------
`default_nettype none
interface tst_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic        is_tcp;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [31:0] ack_number;
	logic [31:0] seq_number;
	logic [15:0] data_size;

	modport source (
		output valid, op, is_tcp, src_addr, dst_addr, src_port, dst_port,
		       ack_number, seq_number, data_size,
		input  ready
	);
	modport sink (
		input  valid, op, is_tcp, src_addr, dst_addr, src_port, dst_port,
		       ack_number, seq_number, data_size,
		output ready
	);
endinterface

interface tst_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        complete;
	logic [31:0] byte_total;

	modport source (output valid, status, complete, byte_total, input ready);
	modport sink (input valid, status, complete, byte_total, output ready);
endinterface
`default_nettype wire

// ===== design/tst_cell.sv =====
// ---------------------------------------------------------------------------
// tst_cell
// One table slot: holds a segment, claims the passing probe on a match or
// as first free slot. Updates hit a claimed slot; open empties all but slot 0.
// ---------------------------------------------------------------------------
`default_nettype none
module tst_cell #(
	parameter bit FIRST = 1'b0
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire tst_pkg::cmd_t            cmd,
	input  wire logic [tst_pkg::SEQ_W-1:0] probe_seq,
	input  wire tst_pkg::probe_t          prb_i,
	output tst_pkg::probe_t               prb_o
);
	import tst_pkg::*;

	logic [SEQ_W-1:0]  seq_q;
	logic [SIZE_W-1:0] size_q;
	logic              valid_q;
	logic              mark_hit_q;
	logic              mark_free_q;
	probe_t            prb_q;
	probe_t            prb_nxt;
	logic              claim_hit;
	logic              claim_free;

	always_comb begin
		claim_hit  = prb_i.pv && !prb_i.hit && valid_q && (seq_q == probe_seq);
		claim_free = prb_i.pv && !prb_i.free && !valid_q;
		prb_nxt = prb_i;
		if (claim_hit) begin
			prb_nxt.hit      = 1'b1;
			prb_nxt.hit_size = size_q;
		end
		if (claim_free) begin
			prb_nxt.free = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			mark_hit_q  <= 1'b0;
			mark_free_q <= 1'b0;
			prb_q       <= '0;
		end else begin
			prb_q <= prb_nxt;
			if (prb_i.pv) begin
				mark_hit_q  <= claim_hit;
				mark_free_q <= claim_free;
			end
			if (cmd.open) begin
				valid_q <= FIRST;
			end else if (cmd.insert && mark_free_q) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.open) begin
			if (FIRST) begin
				seq_q  <= cmd.seq;
				size_q <= cmd.size;
			end
		end else if (cmd.replace && mark_hit_q) begin
			size_q <= cmd.size;
		end else if (cmd.insert && mark_free_q) begin
			seq_q  <= cmd.seq;
			size_q <= cmd.size;
		end
	end

	assign prb_o = prb_q;

endmodule
`default_nettype wire

// ===== design/tcp_segment_tracker.sv =====
// Open beats, complete or foreign adds: result beat valid in the cycle after accept.
// Add beats that go to the table search: result registered as the probe leaves the chain
//   after S_LAUNCH and S_SCAN; the probe walks the cell chain one slot per cycle.
// One header in flight; the next beat can be taken the cycle after the result beat.
// Reset (arst_n low, async): configuration registers 0, all slots empty, count 0, not done.
// ---------------------------------------------------------------------------
// tcp_segment_tracker
// Tracks the segments of one TCP flow until their sizes reach total_size.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tcp_segment_tracker_assert.svh"
module tcp_segment_tracker #(
	parameter int SEGMENTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tst_in_if.sink                             seg_in,
	tst_out_if.source                          res_out,
	input  wire logic                          cfg_we,
	input  wire logic [tst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tst_pkg::CFG_W-1:0]     cfg_data
);
	import tst_pkg::*;

	// configuration registers
	logic [31:0] src_addr_q, dst_addr_q, ack_q, total_size_q;
	logic [15:0] src_port_q, dst_port_q;

	// held header for the search
	logic [SEQ_W-1:0]  seq_q;
	logic [SIZE_W-1:0] size_q;

	// tracker state
	logic [CNT_W-1:0] bc_q;
	logic             done_q;

	// result register
	logic             out_vq;
	logic [2:0]       status_q;
	logic             complete_q;
	logic [CNT_W-1:0] total_q;

	state_t state_q, state_nxt;

	// cell chain: link 0 is fed here, link SEGMENTS is the chain's output
	probe_t chain [SEGMENTS+1];
	probe_t last;
	cmd_t   cmd;

	logic accept, is_open, foreign, launch, commit;
	logic [CNT_W:0] sum_w, adj_w;
	logic [CNT_W-1:0] new_cnt;
	logic           new_done;

	assign accept  = seg_in.valid && seg_in.ready;
	assign is_open = (seg_in.op == OP_OPEN);
	assign last    = chain[SEGMENTS];

	// flow check of an add beat against the reference registers
	assign foreign = !seg_in.is_tcp || (seg_in.src_addr != src_addr_q) ||
	                 (seg_in.dst_addr != dst_addr_q) ||
	                 (seg_in.src_port != src_port_q) ||
	                 (seg_in.dst_port != dst_port_q) ||
	                 (seg_in.ack_number != ack_q) || (seg_in.data_size == '0);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !is_open && !done_q && !foreign) state_nxt = S_LAUNCH;
			end
			S_LAUNCH: state_nxt = S_SCAN;
			S_SCAN: begin
				if (last.pv) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		launch = 1'b0;
		commit = 1'b0;
		case (state_q)
			S_IDLE:   ;
			S_LAUNCH: launch = 1'b1;
			S_SCAN:   commit = last.pv;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_nxt;
	end

	// new byte count: add, remove replaced size (clamp at 0), saturate
	always_comb begin
		sum_w = {1'b0, bc_q} + {{(CNT_W+1-SIZE_W){1'b0}}, size_q};
		adj_w = sum_w;
		if (last.hit) begin
			if (sum_w >= {{(CNT_W+1-SIZE_W){1'b0}}, last.hit_size})
				adj_w = sum_w - {{(CNT_W+1-SIZE_W){1'b0}}, last.hit_size};
			else
				adj_w = '0;
		end
		new_cnt  = adj_w[CNT_W] ? '1 : adj_w[CNT_W-1:0];
		new_done = (new_cnt == total_size_q);
	end

	// broadcast to the cells: open at accept, replace/insert at end of search
	always_comb begin
		cmd.open    = accept && is_open;
		cmd.replace = commit && last.hit;
		cmd.insert  = commit && !last.hit && last.free;
		cmd.seq     = cmd.open ? seg_in.seq_number : seq_q;
		cmd.size    = cmd.open ? seg_in.data_size  : size_q;
	end

	assign chain[0] = '{pv: launch, hit: 1'b0, hit_size: '0, free: 1'b0};

	for (genvar i = 0; i < SEGMENTS; i++) begin : g_cell
		tst_cell #(.FIRST(i == 0)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.probe_seq (seq_q),
			.prb_i     (chain[i]),
			.prb_o     (chain[i+1])
		);
	end

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q   <= '0;
			dst_addr_q   <= '0;
			src_port_q   <= '0;
			dst_port_q   <= '0;
			ack_q        <= '0;
			total_size_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_ADDR:   src_addr_q   <= cfg_data;
				REG_DST_ADDR:   dst_addr_q   <= cfg_data;
				REG_SRC_PORT:   src_port_q   <= cfg_data[15:0];
				REG_DST_PORT:   dst_port_q   <= cfg_data[15:0];
				REG_ACK:        ack_q        <= cfg_data;
				REG_TOTAL_SIZE: total_size_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// count, done flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q   <= '0;
			done_q <= 1'b0;
			out_vq <= 1'b0;
		end else begin
			if (out_vq && res_out.ready) out_vq <= 1'b0;
			if (accept) begin
				if (is_open) begin
					bc_q   <= {{(CNT_W-SIZE_W){1'b0}}, seg_in.data_size};
					done_q <= 1'b0;
					out_vq <= 1'b1;
				end else if (done_q || foreign) begin
					out_vq <= 1'b1;
				end
			end
			if (commit) begin
				if (last.hit || last.free) begin
					bc_q   <= new_cnt;
					done_q <= new_done;
				end
				out_vq <= 1'b1;
			end
		end
	end

	// result payload and held header
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q  <= seg_in.seq_number;
			size_q <= seg_in.data_size;
			if (is_open) begin
				status_q   <= STAT_INSERTED;
				complete_q <= 1'b0;
				total_q    <= {{(CNT_W-SIZE_W){1'b0}}, seg_in.data_size};
			end else if (done_q) begin
				status_q   <= STAT_COMPLETE;
				complete_q <= done_q;
				total_q    <= bc_q;
			end else if (foreign) begin
				status_q   <= STAT_FOREIGN;
				complete_q <= done_q;
				total_q    <= bc_q;
			end
		end
		if (commit) begin
			if (last.hit) begin
				status_q   <= STAT_REPLACED;
				complete_q <= new_done;
				total_q    <= new_cnt;
			end else if (last.free) begin
				status_q   <= STAT_INSERTED;
				complete_q <= new_done;
				total_q    <= new_cnt;
			end else begin
				status_q   <= STAT_FULL;
				complete_q <= done_q;
				total_q    <= bc_q;
			end
		end
	end

	// one header in flight, and never while a result beat is pending
	assign seg_in.ready       = (state_q == S_IDLE) && !out_vq;
	assign res_out.valid      = out_vq;
	assign res_out.status     = status_q;
	assign res_out.complete   = complete_q;
	assign res_out.byte_total = total_q;

	// a header is taken only while no result waits
	`TST_ASSERT_NOW(a_ready_no_pending, seg_in.ready, !res_out.valid)
	// the probe leaves the chain only while the search is running
	`TST_ASSERT_NOW(a_probe_in_scan, last.pv, state_q == S_SCAN)
	// open answers next cycle as an insert that is never complete
	`TST_ASSERT_NEXT(a_open_result, accept && is_open,
		res_out.valid && (res_out.status == STAT_INSERTED) && !res_out.complete)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for tcp_segment_tracker. Segment headers go in through
// a queued valid/ready driver; every result beat is checked against a local
// model of the segment table, byte count and completion flag. Flow registers
// change between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tst_pkg::*;

	localparam int SEGMENTS    = 16;
	localparam int ITEMS       = 1850;
	localparam int QUIET_TAIL  = 250;         // last beats go in with no idling
	localparam int HOLD_CYCLES = 400;         // long result back-pressure
	localparam int STALL_LIMIT = 4000;        // cycles with no beat on either side
	localparam int SETTLE      = SEGMENTS + 4;
	localparam int REPORT_MAX  = 10;

	// indexes past the last register: writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic              op;
		logic              is_tcp;
		logic [31:0]       src_addr;
		logic [31:0]       dst_addr;
		logic [15:0]       src_port;
		logic [15:0]       dst_port;
		logic [31:0]       ack_number;
		logic [SEQ_W-1:0]  seq_number;
		logic [SIZE_W-1:0] data_size;
	} hdr_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             complete;
		logic [CNT_W-1:0] byte_total;
	} res_t;

	// ways an add header can fall outside the tracked flow
	typedef enum int {
		NOT_TCP, BAD_SRC_ADDR, BAD_DST_ADDR, BAD_SRC_PORT, BAD_DST_PORT, BAD_ACK, NO_PAYLOAD
	} flaw_t;

	// how a phase picks total_size against the planned segments
	typedef enum int {PLAN_OVERFILL, PLAN_NEVER_DONE, PLAN_MAX_TOTAL, PLAN_EXACT} plan_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	tst_in_if  hdr_ch ();
	tst_out_if res_ch ();

	tcp_segment_tracker #(.SEGMENTS(SEGMENTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_in    (hdr_ch),
		.res_out   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the flow registers
	logic [31:0] flow_src   = '0;
	logic [31:0] flow_dst   = '0;
	logic [15:0] flow_sport = '0;
	logic [15:0] flow_dport = '0;
	logic [31:0] flow_ack   = '0;
	logic [31:0] flow_total = '0;

	// local copy of the segment table
	logic [SEQ_W-1:0]  seg_seq [SEGMENTS];
	logic [SIZE_W-1:0] seg_len [SEGMENTS];
	logic [SEGMENTS-1:0] seg_live = '0;
	logic [CNT_W-1:0]  byte_cnt    = '0;
	logic              stream_done = 1'b0;

	hdr_t hdr_backlog [$];   // headers waiting for the driver
	res_t predicted   [$];   // results owed by the block, oldest first

	bit   idling    = 1'b0;  // random gaps on both sides
	bit   hold_req  = 1'b0;  // asks the receiver for one long hold
	logic hdr_taken = 1'b0;  // header beat went through at the last rising edge
	int   beats_queued = 0;
	int   bad_results  = 0;
	int   stall_cycles = 0;

	// -----------------------------------------------------------------------
	// Table model: one header in, one result out
	// -----------------------------------------------------------------------
	function automatic res_t track_segment(input hdr_t h);
		res_t        r;
		int          hit;
		int          slot;
		int          i;
		logic [32:0] tally;
		hit      = -1;
		slot     = -1;
		r.status = STAT_INSERTED;
		if (h.op == OP_OPEN) begin
			// open restarts tracking; no flow check, never completes here
			seg_live    = '0;
			seg_seq[0]  = h.seq_number;
			seg_len[0]  = h.data_size;
			seg_live[0] = 1'b1;
			byte_cnt    = CNT_W'(h.data_size);
			stream_done = 1'b0;
		end else if (stream_done) begin
			r.status = STAT_COMPLETE;
		end else if (!h.is_tcp || h.src_addr != flow_src || h.dst_addr != flow_dst ||
				h.src_port != flow_sport || h.dst_port != flow_dport ||
				h.ack_number != flow_ack || h.data_size == '0) begin
			r.status = STAT_FOREIGN;
		end else begin
			// first live entry with the same sequence number wins, else lowest free slot
			for (i = 0; i < SEGMENTS; i++) begin
				if (seg_live[i]) begin
					if (hit < 0 && seg_seq[i] == h.seq_number)
						hit = i;
				end else if (slot < 0) begin
					slot = i;
				end
			end
			tally = {1'b0, byte_cnt} + 33'(h.data_size);
			if (hit >= 0) begin
				tally = (tally >= 33'(seg_len[hit])) ? tally - 33'(seg_len[hit]) : '0;
				seg_len[hit] = h.data_size;
				r.status     = STAT_REPLACED;
			end else if (slot >= 0) begin
				seg_seq[slot]  = h.seq_number;
				seg_len[slot]  = h.data_size;
				seg_live[slot] = 1'b1;
			end else begin
				r.status = STAT_FULL;   // rejected, state untouched
			end
			if (r.status != STAT_FULL) begin
				byte_cnt = tally[32] ? '1 : tally[31:0];   // saturating count
				if (byte_cnt == flow_total)
					stream_done = 1'b1;
			end
		end
		r.complete   = stream_done;
		r.byte_total = byte_cnt;
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Header builders
	// -----------------------------------------------------------------------
	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0:       return '1;
			1:       return 16'd1;
			2:       return 16'($urandom_range(1, 16));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic hdr_t rand_hdr(input logic op);
		hdr_t h;
		h.op         = op;
		h.is_tcp     = 1'($urandom);
		h.src_addr   = $urandom;
		h.dst_addr   = $urandom;
		h.src_port   = 16'($urandom);
		h.dst_port   = 16'($urandom);
		h.ack_number = $urandom;
		h.seq_number = $urandom;
		h.data_size  = 16'($urandom);
		return h;
	endfunction

	// add header that belongs to the current flow
	function automatic hdr_t flow_hdr(input logic [SEQ_W-1:0] seq, input logic [SIZE_W-1:0] len);
		hdr_t h;
		h.op         = OP_ADD;
		h.is_tcp     = 1'b1;
		h.src_addr   = flow_src;
		h.dst_addr   = flow_dst;
		h.src_port   = flow_sport;
		h.dst_port   = flow_dport;
		h.ack_number = flow_ack;
		h.seq_number = seq;
		h.data_size  = len;
		return h;
	endfunction

	function automatic hdr_t foreign_hdr(input hdr_t h, input flaw_t f);
		case (f)
			NOT_TCP:      h.is_tcp     = 1'b0;
			BAD_SRC_ADDR: h.src_addr   ^= 32'd1 << $urandom_range(0, 31);
			BAD_DST_ADDR: h.dst_addr   ^= 32'd1 << $urandom_range(0, 31);
			BAD_SRC_PORT: h.src_port   ^= 16'd1 << $urandom_range(0, 15);
			BAD_DST_PORT: h.dst_port   ^= 16'd1 << $urandom_range(0, 15);
			BAD_ACK:      h.ack_number ^= 32'd1 << $urandom_range(0, 31);
			default:      h.data_size  = '0;
		endcase
		return h;
	endfunction

	task automatic offer(input hdr_t h);
		hdr_backlog.push_back(h);
		beats_queued++;
	endtask

	// -----------------------------------------------------------------------
	// Register writes and idle points
	// -----------------------------------------------------------------------
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_ADDR:   flow_src   = val;
			REG_DST_ADDR:   flow_dst   = val;
			REG_SRC_PORT:   flow_sport = val[15:0];
			REG_DST_PORT:   flow_dport = val[15:0];
			REG_ACK:        flow_ack   = val;
			REG_TOTAL_SIZE: flow_total = val;
			default: ;
		endcase
	endtask

	// sender side holds until every owed result has come back
	task automatic wait_idle();
		@(negedge clk);
		while (hdr_backlog.size() != 0 || hdr_ch.valid || predicted.size() != 0)
			@(negedge clk);
	endtask

	task automatic drain();
		wait_idle();
		repeat (SETTLE) @(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Directed opening: register extremes, flow check per field, replace to
	// completion, refusal once complete, reopen, table full, shrinking replace
	// -----------------------------------------------------------------------
	task automatic directed_checks();
		hdr_t  h;
		flaw_t f;
		int    s;
		set_reg(REG_SRC_ADDR, '1);
		set_reg(REG_DST_ADDR, '0);
		set_reg(REG_SRC_PORT, 32'h0000_FFFF);
		set_reg(REG_DST_PORT, '0);
		set_reg(REG_ACK, '1);
		set_reg(REG_TOTAL_SIZE, 32'h0000_FFFF);
		set_reg(REG_SPARE_LO, '1);
		set_reg(REG_SPARE_HI, $urandom);
		@(posedge clk);
		// open with a foreign key and size == total: inserted, still not complete
		h            = '0;
		h.op         = OP_OPEN;
		h.seq_number = '1;
		h.data_size  = '1;
		offer(h);
		wait_idle();
		// every way to miss the flow
		f = f.first();
		do begin
			offer(foreign_hdr(flow_hdr('1, '1), f));
			f = f.next();
		end while (f != f.first());
		offer(flow_hdr('1, '1));          // same seq: replaced, count hits total
		offer(flow_hdr('0, 16'd1));       // refused, already complete
		h            = rand_hdr(OP_OPEN); // reopen while complete
		h.seq_number = '0;
		h.data_size  = 16'd1;
		offer(h);
		for (s = 1; s < SEGMENTS; s++)
			offer(flow_hdr(32'(s), '1));
		offer(flow_hdr(32'(SEGMENTS), '1)); // no free slot
		offer(flow_hdr(32'd7, 16'd1));      // replace with a smaller size
	endtask

	// -----------------------------------------------------------------------
	// Random phase: new flow registers, then one or two open/add runs with
	// shuffled segments, some replays, some foreign beats, and a tail
	// -----------------------------------------------------------------------
	task automatic flow_phase(input bit long_hold, input bit quiet);
		logic [SEQ_W-1:0]  seqs  [SEGMENTS];
		logic [SIZE_W-1:0] sizes [SEGMENTS];
		logic [31:0]       sum;
		logic [31:0]       total;
		int                order [$];
		int                nseg;
		int                k;
		int                j;
		int                r;
		bit                dup;
		plan_t             plan;
		flaw_t             f;
		hdr_t              h;
		drain();
		idling = !quiet && ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 9))
			0:       plan = PLAN_OVERFILL;
			1:       plan = PLAN_NEVER_DONE;
			2:       plan = PLAN_MAX_TOTAL;
			default: plan = PLAN_EXACT;
		endcase
		nseg = (plan == PLAN_OVERFILL) ? SEGMENTS : $urandom_range(1, SEGMENTS);
		sum  = '0;
		for (k = 0; k < nseg; k++) begin
			dup = 1'b1;
			while (dup) begin
				seqs[k] = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 31)) : pick32();
				dup     = 1'b0;
				for (j = 0; j < k; j++)
					if (seqs[j] == seqs[k])
						dup = 1'b1;
			end
			sizes[k] = pick_size();
			sum     += 32'(sizes[k]);
		end
		case (plan)
			PLAN_OVERFILL:   total = pick32();
			PLAN_NEVER_DONE: total = '0;   // an accepted add never leaves the count at 0
			PLAN_MAX_TOTAL:  total = '1;
			default:         total = sum;
		endcase

		set_reg(REG_SRC_ADDR, pick32());
		set_reg(REG_DST_ADDR, pick32());
		set_reg(REG_SRC_PORT, pick32());
		set_reg(REG_DST_PORT, pick32());
		set_reg(REG_ACK, pick32());
		set_reg(REG_TOTAL_SIZE, total);
		if ($urandom_range(0, 9) == 0)
			set_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
		@(posedge clk);
		if (long_hold)
			hold_req = 1'b1;

		repeat ($urandom_range(1, 2)) begin
			h            = rand_hdr(OP_OPEN);
			h.seq_number = seqs[0];
			h.data_size  = sizes[0];
			offer(h);
			if ($urandom_range(0, 9) == 0)
				wait_idle();
			order.delete();
			for (k = 1; k < nseg; k++)
				order.push_back(k);
			order.shuffle();
			for (j = 0; j < order.size(); j++) begin
				if ($urandom_range(0, 7) == 0) begin
					f = flaw_t'($urandom_range(0, f.num() - 1));
					offer(foreign_hdr(flow_hdr(seqs[order[j]], sizes[order[j]]), f));
				end
				// replay an already stored segment, usually at the same size
				if ($urandom_range(0, 9) == 0) begin
					r = $urandom_range(0, j);
					k = (r == j) ? 0 : order[r];
					offer(flow_hdr(seqs[k], ($urandom_range(0, 4) == 0) ? pick_size() : sizes[k]));
				end
				offer(flow_hdr(seqs[order[j]], sizes[order[j]]));
			end
			if (plan == PLAN_OVERFILL)
				repeat ($urandom_range(1, 3)) offer(flow_hdr($urandom, pick_size()));
			// tail: refused once complete, replacements otherwise
			repeat ($urandom_range(1, 3)) begin
				k = $urandom_range(0, nseg - 1);
				offer(flow_hdr(seqs[k], pick_size()));
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Clock, reset and stimulus
	// -----------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : stimulus
		int phase_no;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		hdr_ch.valid        = 1'b0;
		hdr_ch.op           = 1'b0;
		hdr_ch.is_tcp       = 1'b0;
		hdr_ch.src_addr     = '0;
		hdr_ch.dst_addr     = '0;
		hdr_ch.src_port     = '0;
		hdr_ch.dst_port     = '0;
		hdr_ch.ack_number   = '0;
		hdr_ch.seq_number   = '0;
		hdr_ch.data_size    = '0;
		res_ch.ready        = 1'b0;
		phase_no            = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idling = 1'b1;
		directed_checks();
		while (beats_queued < ITEMS) begin
			phase_no++;
			// phases 2 and 40 run into a long result hold so the input side backs up
			flow_phase(phase_no == 2 || phase_no == 40, beats_queued > ITEMS - QUIET_TAIL);
		end
		drain();
		if (bad_results == 0)
			$display("tcp_segment_tracker verification clean");
		else
			$display("tcp_segment_tracker verification failed");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Header driver: new beat only once the current one is taken
	// -----------------------------------------------------------------------
	always @(negedge clk) begin : drive_hdr
		hdr_t beat;
		int   tx_gap;
		if (arst_n && (!hdr_ch.valid || hdr_taken)) begin
			if (tx_gap != 0) begin
				tx_gap--;
				hdr_ch.valid <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				tx_gap = $urandom_range(0, 12);
				hdr_ch.valid <= 1'b0;
			end else if (hdr_backlog.size() != 0) begin
				beat = hdr_backlog.pop_front();
				hdr_ch.op         <= beat.op;
				hdr_ch.is_tcp     <= beat.is_tcp;
				hdr_ch.src_addr   <= beat.src_addr;
				hdr_ch.dst_addr   <= beat.dst_addr;
				hdr_ch.src_port   <= beat.src_port;
				hdr_ch.dst_port   <= beat.dst_port;
				hdr_ch.ack_number <= beat.ack_number;
				hdr_ch.seq_number <= beat.seq_number;
				hdr_ch.data_size  <= beat.data_size;
				hdr_ch.valid      <= 1'b1;
			end else begin
				hdr_ch.valid <= 1'b0;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result receiver: random back-pressure plus each requested long hold
	// -----------------------------------------------------------------------
	always @(negedge clk) begin : drive_ready
		int rx_gap;
		int rx_hold;
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 1'b0;
				rx_hold  = HOLD_CYCLES;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				res_ch.ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				res_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(0, 12);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: predict on each header beat, check each result beat in order
	// -----------------------------------------------------------------------
	always @(posedge clk) begin : watch_beats
		hdr_t hdr_seen;
		res_t got;
		res_t want;
		if (arst_n) begin
			hdr_taken <= hdr_ch.valid && hdr_ch.ready;
			if (hdr_ch.valid && hdr_ch.ready) begin
				hdr_seen = '{op: hdr_ch.op, is_tcp: hdr_ch.is_tcp,
					src_addr: hdr_ch.src_addr, dst_addr: hdr_ch.dst_addr,
					src_port: hdr_ch.src_port, dst_port: hdr_ch.dst_port,
					ack_number: hdr_ch.ack_number, seq_number: hdr_ch.seq_number,
					data_size: hdr_ch.data_size};
				predicted.push_back(track_segment(hdr_seen));
			end
			if (res_ch.valid && res_ch.ready) begin
				got = '{status: res_ch.status, complete: res_ch.complete,
					byte_total: res_ch.byte_total};
				if (predicted.size() == 0) begin
					if (bad_results < REPORT_MAX)
						$display("%0t: result beat with nothing owed: status %0d complete %0b bytes %0d",
							$time, got.status, got.complete, got.byte_total);
					bad_results++;
				end else begin
					want = predicted.pop_front();
					if (got.status !== want.status || got.complete !== want.complete ||
							got.byte_total !== want.byte_total) begin
						if (bad_results < REPORT_MAX)
							$display({"%0t: result mismatch: expected status %0d complete %0b bytes %0d,",
								" got status %0d complete %0b bytes %0d"}, $time,
								want.status, want.complete, want.byte_total,
								got.status, got.complete, got.byte_total);
						bad_results++;
					end
				end
			end
		end
	end

	// watchdog: too long with no beat on either channel means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tcp_segment_tracker verification failed");
				$finish;
			end
		end
	end

endmodule
